// ----- sv/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as its trigger
`define MEAB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition holds in the cycle after its trigger
`define MEAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/meab_pkg.sv -----
// package with constants and types of the mesh edge adjacency builder
package meab_pkg;

  localparam int unsigned NumVerts  = 65536;
  localparam int unsigned NumTris   = 65536;
  localparam int unsigned NumEdges  = 196608;
  localparam int unsigned NumChains = 2 * NumEdges;

  localparam int unsigned VertW  = 16;
  localparam int unsigned EdgeW  = 18;
  localparam int unsigned ChainW = 19;
  localparam int unsigned TriW   = 17;
  localparam int unsigned CntW   = 17;

  localparam logic [ChainW-1:0] ChainNone  = '1;
  localparam logic [EdgeW-1:0]  CornerNone = '1;

  // configuration register indexes
  localparam logic RegStripMode   = 1'b0;
  localparam logic RegVertexCount = 1'b1;

  // error codes
  localparam logic [1:0] ErrNone  = 2'd0;
  localparam logic [1:0] ErrRange = 2'd1;
  localparam logic [1:0] ErrFull  = 2'd2;

  typedef enum logic [3:0] {
    StReset,
    StIdle,
    StClear,
    StDispatch,
    StHeadRd,
    StHeadWait,
    StWalkRd,
    StWalkCmp,
    StAppRd,
    StAppW1,
    StAppW2,
    StFoundRd,
    StFoundWr,
    StNextK,
    StFinish
  } state_e;

endpackage

// ----- sv/mesh_edge_adjacency_builder_top.sv -----
// top level of the mesh edge adjacency builder
`include "assert_macros.svh"

// Takes one vertex index per request and gives one result per completed triangle
// (or an error result). All tables sit in single-port-style synchronous memories
// and one sequencer walks them. Per corner it reads the vertex chain head, walks
// the edge-chain entries until a match or the end, and appends a new edge if none
// matched; a triangle also passes accept, dispatch and the result register, and
// waits there while the previous result is still held. An index that completes no
// triangle, or an error triangle, skips the walk. A request with start_req set
// first clears the 65536 vertex chain heads, one per cycle; the same pass runs
// once after reset, taking no request. Configuration writes are taken anytime.
module mesh_edge_adjacency_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] vertex_index_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] triangle_index_o,
  output logic [17:0] edge_0_o,
  output logic [17:0] edge_1_o,
  output logic [17:0] edge_2_o,
  output logic [17:0] link_0_o,
  output logic [17:0] link_1_o,
  output logic [17:0] link_2_o,
  output logic [17:0] edges_so_far_o,
  output logic [1:0]  error_o
);

  localparam int unsigned VW = meab_pkg::VertW;
  localparam int unsigned EW = meab_pkg::EdgeW;
  localparam int unsigned CW = meab_pkg::ChainW;

  // memories
  logic [CW-1:0]   head_mem   [meab_pkg::NumVerts];
  logic [2*VW-1:0] ends_mem   [meab_pkg::NumEdges];
  logic [CW-1:0]   next_mem   [meab_pkg::NumChains];
  logic [EW-1:0]   corner_mem [meab_pkg::NumEdges];

  logic            head_re, head_we;
  logic [VW-1:0]   head_raddr, head_waddr;
  logic [CW-1:0]   head_wdata, head_rdata_q;
  logic            ends_re, ends_we;
  logic [EW-1:0]   ends_raddr, ends_waddr;
  logic [2*VW-1:0] ends_wdata, ends_rdata_q;
  logic            next_re, next_we;
  logic [CW-1:0]   next_raddr, next_waddr;
  logic [CW-1:0]   next_wdata, next_rdata_q;
  logic            corner_re, corner_we;
  logic [EW-1:0]   corner_raddr, corner_waddr;
  logic [EW-1:0]   corner_wdata, corner_rdata_q;

  meab_pkg::state_e state_q, state_d;

  logic                      strip_q;
  logic [meab_pkg::CntW-1:0] vcount_q;
  logic [VW-1:0]             clr_cnt_q;
  logic                      clr_item_q;
  logic [VW-1:0]             v_q;
  logic [VW-1:0]             recent_q [2];
  logic [1:0]                phase_q;
  logic [VW-1:0]             cor_q [3];
  logic [1:0]                k_q;
  logic [CW-1:0]             cur_q, hlo_q;
  logic [CW-1:0]             steps_q;
  logic [EW-1:0]             e_q;
  logic [EW-1:0]             edges_q [3];
  logic [EW-1:0]             links_q [3];
  logic [1:0]                err_q;
  logic [EW-1:0]             edge_total_q;
  logic [meab_pkg::TriW-1:0] tri_total_q;
  logic                      out_valid_q;

  // corner and edge end selection
  logic [VW-1:0] ca, cb, lo, hi;
  always_comb begin
    case (k_q)
      2'd0: begin
        ca = cor_q[1];
        cb = cor_q[2];
      end
      2'd1: begin
        ca = cor_q[2];
        cb = cor_q[0];
      end
      default: begin
        ca = cor_q[0];
        cb = cor_q[1];
      end
    endcase
    lo = (ca < cb) ? ca : cb;
    hi = (ca < cb) ? cb : ca;
  end

  // walk termination and match
  logic [CW:0] walk_bound;
  logic        walk_stop, walk_match;
  assign walk_bound = {1'b0, edge_total_q, 1'b0} + (CW+1)'(2);
  assign walk_stop  = (cur_q == meab_pkg::ChainNone) || ({1'b0, steps_q} > walk_bound)
                      || (cur_q[CW-1:1] >= edge_total_q);
  assign walk_match = (ends_rdata_q == {lo, hi});

  // triangle checks at dispatch
  logic       range_bad, table_full, tri_ready;
  logic [18:0] edge_room;
  assign tri_ready  = (phase_q >= 2'd2);
  assign range_bad  = ({1'b0, recent_q[0]} >= vcount_q) || ({1'b0, recent_q[1]} >= vcount_q)
                      || ({1'b0, v_q} >= vcount_q);
  assign edge_room  = {1'b0, edge_total_q} + 19'd3;
  assign table_full = (tri_total_q >= meab_pkg::TriW'(meab_pkg::NumTris))
                      || (edge_room > 19'(meab_pkg::NumEdges));

  logic [EW-1:0] corner_id;
  assign corner_id = {tri_total_q[15:0], k_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      meab_pkg::StReset:    state_d = meab_pkg::StClear;
      meab_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = start_req_i ? meab_pkg::StClear : meab_pkg::StDispatch;
        end
      end
      meab_pkg::StClear: begin
        if (clr_cnt_q == '1) begin
          state_d = clr_item_q ? meab_pkg::StDispatch : meab_pkg::StIdle;
        end
      end
      meab_pkg::StDispatch: begin
        if (!tri_ready) begin
          state_d = meab_pkg::StIdle;
        end else if (range_bad || table_full) begin
          state_d = meab_pkg::StFinish;
        end else begin
          state_d = meab_pkg::StHeadRd;
        end
      end
      meab_pkg::StHeadRd:   state_d = meab_pkg::StHeadWait;
      meab_pkg::StHeadWait: state_d = meab_pkg::StWalkRd;
      meab_pkg::StWalkRd:   state_d = walk_stop ? meab_pkg::StAppRd : meab_pkg::StWalkCmp;
      meab_pkg::StWalkCmp:  state_d = walk_match ? meab_pkg::StFoundRd : meab_pkg::StWalkRd;
      meab_pkg::StAppRd:    state_d = meab_pkg::StAppW1;
      meab_pkg::StAppW1:    state_d = meab_pkg::StAppW2;
      meab_pkg::StAppW2:    state_d = meab_pkg::StNextK;
      meab_pkg::StFoundRd:  state_d = meab_pkg::StFoundWr;
      meab_pkg::StFoundWr:  state_d = meab_pkg::StNextK;
      meab_pkg::StNextK: begin
        state_d = (k_q == 2'd2) ? meab_pkg::StFinish : meab_pkg::StHeadRd;
      end
      meab_pkg::StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = meab_pkg::StIdle;
        end
      end
      default: state_d = meab_pkg::StReset;
    endcase
  end

  // memory port control
  always_comb begin
    head_re      = 1'b0;
    head_raddr   = lo;
    head_we      = 1'b0;
    head_waddr   = lo;
    head_wdata   = meab_pkg::ChainNone;
    ends_re      = 1'b0;
    ends_raddr   = cur_q[CW-1:1];
    ends_we      = 1'b0;
    ends_waddr   = e_q;
    ends_wdata   = {lo, hi};
    next_re      = 1'b0;
    next_raddr   = cur_q;
    next_we      = 1'b0;
    next_waddr   = {e_q, 1'b0};
    next_wdata   = hlo_q;
    corner_re    = 1'b0;
    corner_raddr = e_q;
    corner_we    = 1'b0;
    corner_waddr = e_q;
    corner_wdata = corner_id;
    case (state_q)
      meab_pkg::StClear: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt_q;
      end
      meab_pkg::StHeadRd: head_re = 1'b1;
      meab_pkg::StWalkRd: begin
        ends_re = !walk_stop;
        next_re = !walk_stop;
      end
      meab_pkg::StAppRd: begin
        head_re    = 1'b1;
        head_raddr = hi;
      end
      meab_pkg::StAppW1: begin
        head_we    = 1'b1;
        head_waddr = lo;
        head_wdata = {e_q, 1'b0};
        ends_we    = 1'b1;
        next_we    = 1'b1;
      end
      meab_pkg::StAppW2: begin
        head_we    = 1'b1;
        head_waddr = hi;
        head_wdata = {e_q, 1'b1};
        next_we    = 1'b1;
        next_waddr = {e_q, 1'b1};
        next_wdata = head_rdata_q;
        corner_we  = 1'b1;
      end
      meab_pkg::StFoundRd: corner_re = 1'b1;
      meab_pkg::StFoundWr: corner_we = 1'b1;
      default: ;
    endcase
  end

  // synchronous memories
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rdata_q <= head_mem[head_raddr];
    end
    if (ends_we) begin
      ends_mem[ends_waddr] <= ends_wdata;
    end
    if (ends_re) begin
      ends_rdata_q <= ends_mem[ends_raddr];
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (next_re) begin
      next_rdata_q <= next_mem[next_raddr];
    end
    if (corner_we) begin
      corner_mem[corner_waddr] <= corner_wdata;
    end
    if (corner_re) begin
      corner_rdata_q <= corner_mem[corner_raddr];
    end
  end

  // control state, counts and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= meab_pkg::StReset;
      strip_q      <= 1'b0;
      vcount_q     <= meab_pkg::CntW'(meab_pkg::NumVerts);
      clr_cnt_q    <= '0;
      clr_item_q   <= 1'b0;
      recent_q[0]  <= '0;
      recent_q[1]  <= '0;
      phase_q      <= '0;
      k_q          <= '0;
      edge_total_q <= '0;
      tri_total_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == meab_pkg::RegStripMode) begin
          strip_q <= cfg_data_i[0];
        end else begin
          vcount_q <= cfg_data_i;
        end
      end
      case (state_q)
        meab_pkg::StReset: begin
          clr_cnt_q  <= '0;
          clr_item_q <= 1'b0;
        end
        meab_pkg::StIdle: begin
          if (in_valid_i && start_req_i) begin
            clr_cnt_q    <= '0;
            clr_item_q   <= 1'b1;
            edge_total_q <= '0;
            tri_total_q  <= '0;
            phase_q      <= '0;
          end
        end
        meab_pkg::StClear: clr_cnt_q <= clr_cnt_q + VW'(1);
        meab_pkg::StDispatch: begin
          k_q <= '0;
          if (!tri_ready) begin
            recent_q[phase_q[0]] <= v_q;
            phase_q              <= phase_q + 2'd1;
          end else if (strip_q) begin
            recent_q[0] <= recent_q[1];
            recent_q[1] <= v_q;
            phase_q     <= 2'd2;
          end else begin
            phase_q <= '0;
          end
        end
        meab_pkg::StAppW2: edge_total_q <= edge_total_q + EW'(1);
        meab_pkg::StNextK: k_q <= k_q + 2'd1;
        meab_pkg::StFinish: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            if (err_q == meab_pkg::ErrNone) begin
              tri_total_q <= tri_total_q + meab_pkg::TriW'(1);
            end
          end
        end
        default: ;
      endcase
      if (out_valid_q && out_ready_i && !(state_q == meab_pkg::StFinish)) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      meab_pkg::StIdle: begin
        if (in_valid_i) begin
          v_q <= vertex_index_i;
        end
      end
      meab_pkg::StDispatch: begin
        cor_q[0] <= recent_q[0];
        cor_q[1] <= recent_q[1];
        cor_q[2] <= v_q;
        err_q    <= range_bad ? meab_pkg::ErrRange
                  : (table_full ? meab_pkg::ErrFull : meab_pkg::ErrNone);
        for (int i = 0; i < 3; i++) begin
          edges_q[i] <= '0;
          links_q[i] <= meab_pkg::CornerNone;
        end
      end
      meab_pkg::StHeadWait: begin
        cur_q   <= head_rdata_q;
        hlo_q   <= head_rdata_q;
        steps_q <= '0;
      end
      meab_pkg::StWalkCmp: begin
        if (walk_match) begin
          e_q <= cur_q[CW-1:1];
        end else begin
          cur_q   <= next_rdata_q;
          steps_q <= steps_q + CW'(1);
        end
      end
      meab_pkg::StAppRd: e_q <= edge_total_q;
      meab_pkg::StAppW2: begin
        edges_q[k_q] <= e_q;
        links_q[k_q] <= meab_pkg::CornerNone;
      end
      meab_pkg::StFoundWr: begin
        edges_q[k_q] <= e_q;
        links_q[k_q] <= corner_rdata_q;
      end
      meab_pkg::StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          triangle_index_o <= tri_total_q[15:0];
          edge_0_o         <= edges_q[0];
          edge_1_o         <= edges_q[1];
          edge_2_o         <= edges_q[2];
          link_0_o         <= links_q[0];
          link_1_o         <= links_q[1];
          link_2_o         <= links_q[2];
          edges_so_far_o   <= edge_total_q;
          error_o          <= err_q;
        end
      end
      default: ;
    endcase
  end

  // handshake outputs
  assign in_ready_o  = (state_q == meab_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  // checks
  `MEAB_ASSERT_NOW(a_err_fields, out_valid_o && (error_o != meab_pkg::ErrNone),
                   (edge_0_o == '0) && (link_0_o == meab_pkg::CornerNone))
  `MEAB_ASSERT_NOW(a_walk_live, state_q == meab_pkg::StWalkCmp,
                   cur_q != meab_pkg::ChainNone)
  `MEAB_ASSERT_NEXT(a_edge_grow, state_q == meab_pkg::StAppW2,
                    edge_total_q == $past(edge_total_q) + EW'(1))
  `MEAB_ASSERT_NOW(a_edge_cap, out_valid_o,
                   edges_so_far_o <= EW'(meab_pkg::NumEdges))

endmodule
